>>> rtl/bgre_pkg.sv
// shared constants, types and helpers of the binary grid run extractor
`default_nettype none

package bgre_pkg;

  localparam int MaxDim  = 128;
  localparam int PosW    = $clog2(MaxDim);
  localparam int DimW    = $clog2(MaxDim + 1);
  localparam int CfgIdxW = 2;

  localparam int FifoDepth = 8;
  localparam int FifoAw    = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [CfgIdxW-1:0] CfgGridWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgGridHeight = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgMinRunLen  = CfgIdxW'(2);

  localparam logic DirHorizontal = 1'b0;
  localparam logic DirVertical   = 1'b1;

  typedef struct packed {
    logic            dir;
    logic [PosW-1:0] row;
    logic [PosW-1:0] col;
    logic [DimW-1:0] len;
    logic            last;
  } result_t;

  // line store entry: open flag and start row of the open vertical run
  typedef struct packed {
    logic            open;
    logic [PosW-1:0] start;
  } vent_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > DimW'(MaxDim)) begin
      r = DimW'(MaxDim);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/bgre_if.sv
// valid/ready channel interfaces of the binary grid run extractor
`default_nettype none

interface bgre_pix_if;
  logic valid;
  logic ready;
  logic pixel_bit;

  modport source (output valid, output pixel_bit, input ready);
  modport sink (input valid, input pixel_bit, output ready);
endinterface

interface bgre_run_if;
  logic                      valid;
  logic                      ready;
  logic                      run_direction;
  logic [bgre_pkg::PosW-1:0] first_row;
  logic [bgre_pkg::PosW-1:0] start_column;
  logic [bgre_pkg::DimW-1:0] run_length;
  logic                      last_of_item;

  modport source (output valid, output run_direction, output first_row,
                  output start_column, output run_length, output last_of_item,
                  input ready);
  modport sink (input valid, input run_direction, input first_row,
                input start_column, input run_length, input last_of_item,
                output ready);
endinterface

interface bgre_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [bgre_pkg::CfgIdxW-1:0] index;
  logic [bgre_pkg::DimW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/binary_grid_run_extractor_unit.sv
// Binary grid run extractor: raster pixel stream in, closed runs out.
//
// pix_i carries one pixel word per handshake in raster order. run_o gives one
// word per reported run (direction, start row, start column, length) with
// last_of_item set on the final run caused by a pixel; a pixel closing both a
// horizontal and a vertical run gives the horizontal one first. cfg_i writes
// grid width (index 0), grid height (1) and minimum run length (2); writing a
// size restarts the grid and drops open runs. Write config only when idle.
// Pixels are taken one per cycle while the output queue has room. A pixel is
// read against the line store in the accept cycle, is held in the stage 1
// registers, and its runs are written from stage 1 into an 8-word output queue;
// run_o offers the queued runs in order, each taken on a valid/ready handshake.
// A same-column back-to-back access (width 1) is covered by write forwarding.
// pix_i.ready drops when the output queue could not take the runs of the
// pixel in stage 1 and of one more; a stalled receiver thus backs up into
// pix_i after a few words. Reset (and a size write) clears the counters and
// the per-column valid flags at once; there is no clearing pass. cfg_i is
// always ready.
`default_nettype none

module binary_grid_run_extractor_unit (
  input  wire             clk_i,
  input  wire             rst_ni,
  bgre_pix_if.sink        pix_i,
  bgre_cfg_if.sink        cfg_i,
  bgre_run_if.source      run_o
);

  localparam int PosW = bgre_pkg::PosW;
  localparam int DimW = bgre_pkg::DimW;

  // configuration
  logic [DimW-1:0] width_q, height_q, minlen_q;
  logic            cfg_acc, restart;

  assign cfg_i.ready = 1'b1;
  assign cfg_acc = cfg_i.valid & cfg_i.ready;
  assign restart = cfg_acc & ((cfg_i.index == bgre_pkg::CfgGridWidth) ||
                              (cfg_i.index == bgre_pkg::CfgGridHeight));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimW'(bgre_pkg::MaxDim);
      height_q <= DimW'(bgre_pkg::MaxDim);
      minlen_q <= DimW'(2);
    end else if (cfg_acc) begin
      unique case (cfg_i.index)
        bgre_pkg::CfgGridWidth:  width_q  <= bgre_pkg::clamp_dim(cfg_i.data);
        bgre_pkg::CfgGridHeight: height_q <= bgre_pkg::clamp_dim(cfg_i.data);
        bgre_pkg::CfgMinRunLen: begin
          minlen_q <= (cfg_i.data == '0) ? DimW'(1) : cfg_i.data;
        end
        default: ;
      endcase
    end
  end

  // stage 0: position counters and horizontal run
  logic [PosW-1:0] row_q, row_d, col_q, col_d;
  logic            h_open_q, h_open_d;
  logic [PosW-1:0] h_start_q, h_start_d;
  logic            in_acc, pix, last_col, last_row;
  logic            h_open_now, h_close, h_emit;
  logic [PosW-1:0] h_start_now;
  logic [DimW-1:0] h_end, h_len;

  assign in_acc   = pix_i.valid & pix_i.ready;
  assign pix      = pix_i.pixel_bit;
  assign last_col = ({1'b0, col_q} + DimW'(1)) >= width_q;
  assign last_row = ({1'b0, row_q} + DimW'(1)) >= height_q;

  always_comb begin
    h_open_now  = h_open_q | pix;
    h_start_now = h_open_q ? h_start_q : col_q;
    h_close     = h_open_now & (~pix | last_col);
    h_end       = {1'b0, col_q} + DimW'(pix);
    h_len       = h_end - {1'b0, h_start_now};
    h_emit      = h_close & (h_len >= minlen_q);
    h_open_d    = h_open_now & ~h_close;
    h_start_d   = h_close ? '0 : h_start_now;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : PosW'({1'b0, row_q} + DimW'(1));
    end else begin
      col_d = PosW'({1'b0, col_q} + DimW'(1));
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q     <= '0;
      col_q     <= '0;
      h_open_q  <= 1'b0;
      h_start_q <= '0;
    end else if (restart) begin
      row_q     <= '0;
      col_q     <= '0;
      h_open_q  <= 1'b0;
      h_start_q <= '0;
    end else if (in_acc) begin
      row_q     <= row_d;
      col_q     <= col_d;
      h_open_q  <= h_open_d;
      h_start_q <= h_start_d;
    end
  end

  // stage 1 registers
  logic              s1_v_q;
  logic              s1_pix_q, s1_last_row_q, s1_h_emit_q;
  logic [PosW-1:0]   s1_row_q, s1_col_q;
  bgre_pkg::result_t s1_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q      <= pix;
      s1_last_row_q <= last_row;
      s1_h_emit_q   <= h_emit;
      s1_row_q      <= row_q;
      s1_col_q      <= col_q;
      s1_h_q.dir    <= bgre_pkg::DirHorizontal;
      s1_h_q.row    <= row_q;
      s1_h_q.col    <= h_start_now;
      s1_h_q.len    <= h_len;
      s1_h_q.last   <= 1'b0;
    end
  end

  // line store: read at accept, write back in stage 1
  bgre_pkg::vent_t          mem [bgre_pkg::MaxDim];
  bgre_pkg::vent_t          rdata_q, wdata, fwd_dat_q, v_ent;
  logic [bgre_pkg::MaxDim-1:0] vld_q;
  logic                     fwd_v_q;
  logic [PosW-1:0]          fwd_col_q;
  logic                     v_open, v_open_now, v_close, v_emit;
  logic [PosW-1:0]          v_start_now;
  logic [DimW-1:0]          v_end, v_len;

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      mem[s1_col_q] <= wdata;
    end
    if (in_acc) begin
      rdata_q <= mem[col_q];
    end
  end

  always_comb begin
    v_ent       = (fwd_v_q && (fwd_col_q == s1_col_q)) ? fwd_dat_q : rdata_q;
    v_open      = vld_q[s1_col_q] & v_ent.open;
    v_open_now  = v_open | s1_pix_q;
    v_start_now = v_open ? v_ent.start : s1_row_q;
    v_close     = v_open_now & (~s1_pix_q | s1_last_row_q);
    v_end       = {1'b0, s1_row_q} + DimW'(s1_pix_q);
    v_len       = v_end - {1'b0, v_start_now};
    v_emit      = s1_v_q & v_close & (v_len >= minlen_q);
    wdata.open  = v_open_now & ~v_close;
    wdata.start = (v_open_now & ~v_close) ? v_start_now : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      fwd_v_q <= 1'b0;
    end else if (restart) begin
      vld_q   <= '0;
      fwd_v_q <= 1'b0;
    end else if (s1_v_q) begin
      vld_q[s1_col_q] <= 1'b1;
      fwd_v_q         <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      fwd_col_q <= s1_col_q;
      fwd_dat_q <= wdata;
    end
  end

  // output queue
  bgre_pkg::result_t               fifo_q [bgre_pkg::FifoDepth];
  logic [bgre_pkg::FifoAw-1:0]     wr_ptr_q, rd_ptr_q, wr_ptr_nx;
  logic [bgre_pkg::FifoCntW-1:0]   cnt_q;
  bgre_pkg::result_t               v_res, h_res, head;
  logic                            push_h, push_v, pop;
  logic [1:0]                      n_push;

  assign push_h    = s1_v_q & s1_h_emit_q;
  assign push_v    = v_emit;
  assign n_push    = 2'(push_h) + 2'(push_v);
  assign wr_ptr_nx = bgre_pkg::FifoAw'(wr_ptr_q + 1'b1);
  assign pop       = run_o.valid & run_o.ready;

  always_comb begin
    h_res      = s1_h_q;
    h_res.last = ~push_v;
    v_res.dir  = bgre_pkg::DirVertical;
    v_res.row  = v_start_now;
    v_res.col  = s1_col_q;
    v_res.len  = v_len;
    v_res.last = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (push_h) begin
      fifo_q[wr_ptr_q] <= h_res;
      if (push_v) begin
        fifo_q[wr_ptr_nx] <= v_res;
      end
    end else if (push_v) begin
      fifo_q[wr_ptr_q] <= v_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= bgre_pkg::FifoAw'(wr_ptr_q + bgre_pkg::FifoAw'(n_push));
      rd_ptr_q <= bgre_pkg::FifoAw'(rd_ptr_q + bgre_pkg::FifoAw'(pop));
      cnt_q    <= bgre_pkg::FifoCntW'(cnt_q + bgre_pkg::FifoCntW'(n_push)
                                      - bgre_pkg::FifoCntW'(pop));
    end
  end

  // room for the runs of the pixel in stage 1 and of the one taken now
  assign pix_i.ready = s1_v_q ?
      (cnt_q <= bgre_pkg::FifoCntW'(bgre_pkg::FifoDepth - 4)) :
      (cnt_q <= bgre_pkg::FifoCntW'(bgre_pkg::FifoDepth - 2));

  assign head               = fifo_q[rd_ptr_q];
  assign run_o.valid        = (cnt_q != '0);
  assign run_o.run_direction = head.dir;
  assign run_o.first_row    = head.row;
  assign run_o.start_column = head.col;
  assign run_o.run_length   = head.len;
  assign run_o.last_of_item = head.last;

`ifndef SYNTHESIS
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= bgre_pkg::FifoCntW'(bgre_pkg::FifoDepth))
    else $error("output queue overflow");

  a_col_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, col_q} < width_q) && ({1'b0, row_q} < height_q))
    else $error("raster position outside grid");

  a_row_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_col && !restart) |=> !h_open_q)
    else $error("horizontal run left open across a row end");

  a_run_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_o.valid |-> (run_o.run_length != '0))
    else $error("zero length run emitted");
`endif

endmodule

`default_nettype wire
